### sv/kns_pkg.sv
// kns_pkg: shared types and constants of the k-nearest sorted insertion unit
// used by kns_cell and k_nearest_sorted_insert_unit; no dependencies
package kns_pkg;

  // list geometry and field widths
  localparam int CAPACITY  = 16;
  localparam int ITEM_BITS = 16;
  localparam int DIST_BITS = 32;
  localparam int IDX_BITS  = 4;
  localparam int CNT_BITS  = 5;

  // configuration register
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam logic [DIST_BITS-1:0] EMPTY_MAX_RESET = DIST_BITS'(1000000);

  // register indexes
  typedef enum logic {
    REG_EMPTY_MAX = 1'b0
  } kns_reg_t;

  // request commands
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } kns_cmd_t;

  // input request
  typedef struct packed {
    logic                 command;
    logic [ITEM_BITS-1:0] item_id;
    logic [DIST_BITS-1:0] distance;
    logic [IDX_BITS-1:0]  entry_index;
  } kns_in_t;

  // result
  typedef struct packed {
    logic                 inserted;
    logic [CNT_BITS-1:0]  entry_count;
    logic [DIST_BITS-1:0] worst_distance;
    logic                 nearest_valid;
    logic [ITEM_BITS-1:0] nearest_item;
    logic [ITEM_BITS-1:0] read_item;
    logic [DIST_BITS-1:0] read_distance;
    logic                 read_error;
  } kns_out_t;

  // what one cell shows its right-hand neighbor and the top level
  typedef struct packed {
    logic                 valid;
    logic                 le;    // valid and distance <= candidate
    logic                 gt;    // valid and distance > candidate
    logic [DIST_BITS-1:0] dist_val;
    logic [ITEM_BITS-1:0] item;
  } kns_tap_t;

endpackage

### sv/k_nearest_sorted_insert_unit.sv
// Keeps the CAPACITY smallest-distance candidates in a chain of cells, sorted ascending,
// ties in arrival order. One request is taken per clock while the output register is free
// or being taken: every cell compares its entry with the candidate at once and shifts right
// or takes the candidate in the same cycle, and the result sits in an output register; the
// next request is taken while that result is being taken. Reset leaves an empty list.
// depends on kns_pkg and kns_cell
module k_nearest_sorted_insert_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  kns_pkg::kns_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output kns_pkg::kns_out_t                 out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kns_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [kns_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [kns_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  localparam int PEN = (kns_pkg::CAPACITY > 1) ? kns_pkg::CAPACITY - 2 : 0;
  localparam logic [kns_pkg::CNT_BITS-1:0] CNT_FULL = kns_pkg::CNT_BITS'(kns_pkg::CAPACITY);

  logic [kns_pkg::DIST_BITS-1:0] emax_r;
  logic [kns_pkg::CNT_BITS-1:0]  count_r, count_nxt;
  logic [kns_pkg::DIST_BITS-1:0] worst_r, worst_nxt;
  logic                          out_valid_r;
  kns_pkg::kns_out_t             out_r, out_nxt;

  kns_pkg::kns_tap_t             taps [kns_pkg::CAPACITY];
  kns_pkg::kns_tap_t             head_tap;
  logic [kns_pkg::CAPACITY-1:0]  valid_vec;
  logic [kns_pkg::CAPACITY-1:0]  order_ok;

  logic                          accept, is_insert, full, keep, ins, rd_ok, cfg_wr;
  logic [kns_pkg::DIST_BITS-1:0] pen_dist;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == kns_pkg::REG_EMPTY_MAX);
  assign prdata = (paddr[2] == kns_pkg::REG_EMPTY_MAX) ? emax_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emax_r <= kns_pkg::EMPTY_MAX_RESET;
    end else if (cfg_wr) begin
      emax_r <= pwdata;
    end
  end

  // request handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_insert = (in_data.command == kns_pkg::CMD_INSERT);
  assign full      = (count_r == CNT_FULL);
  assign keep      = !full || taps[kns_pkg::CAPACITY-1].gt;
  assign ins       = accept && is_insert && keep;

  // cell chain, head sees an always-smaller left neighbor
  always_comb begin
    head_tap       = '0;
    head_tap.valid = 1'b1;
    head_tap.le    = 1'b1;
  end

  genvar g;
  generate
    for (g = 0; g < kns_pkg::CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        kns_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ins       (ins),
          .cand_dist (in_data.distance),
          .cand_item (in_data.item_id),
          .prev      (head_tap),
          .tap       (taps[g])
        );
        assign order_ok[g] = 1'b1;
      end else begin : g_body
        kns_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ins       (ins),
          .cand_dist (in_data.distance),
          .cand_item (in_data.item_id),
          .prev      (taps[g-1]),
          .tap       (taps[g])
        );
        assign order_ok[g] = !taps[g].valid ||
                             (taps[g-1].valid && (taps[g-1].dist_val <= taps[g].dist_val));
      end
      assign valid_vec[g] = taps[g].valid;
    end
  endgenerate

  // second-to-last entry becomes a worst candidate when the last falls off
  assign pen_dist = (kns_pkg::CAPACITY > 1) ? taps[PEN].dist_val : in_data.distance;

  // count and worst distance tracking
  always_comb begin
    count_nxt = count_r;
    worst_nxt = worst_r;
    if (ins) begin
      if (count_r == '0) begin
        count_nxt = count_r + 1'b1;
        worst_nxt = in_data.distance;
      end else if (!full) begin
        count_nxt = count_r + 1'b1;
        worst_nxt = (in_data.distance >= worst_r) ? in_data.distance : worst_r;
      end else begin
        worst_nxt = (in_data.distance >= pen_dist) ? in_data.distance : pen_dist;
      end
    end
  end

  // read port and result assembly
  assign rd_ok = !is_insert && ({1'b0, in_data.entry_index} < count_r);

  always_comb begin
    out_nxt                = '0;
    out_nxt.inserted       = is_insert && keep;
    out_nxt.entry_count    = count_nxt;
    out_nxt.nearest_valid  = (count_nxt != '0);
    out_nxt.worst_distance = (count_nxt != '0) ? worst_nxt : emax_r;
    if (count_nxt != '0) begin
      out_nxt.nearest_item = (ins && !taps[0].le) ? in_data.item_id : taps[0].item;
    end
    if (rd_ok) begin
      out_nxt.read_item     = taps[in_data.entry_index].item;
      out_nxt.read_distance = taps[in_data.entry_index].dist_val;
    end
    out_nxt.read_error = !is_insert && !rd_ok;
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      worst_r <= worst_nxt;
      out_r   <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above capacity");

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("valid cells disagree with entry count");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    &order_ok)
    else $error("chain lost ascending order");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ins && !full) |=> (count_r == $past(count_r) + 1'b1))
    else $error("kept insert did not grow a partial list");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("request refused with empty output register");

endmodule

### sv/kns_cell.sv
// kns_cell: one slot of the sorted insertion chain
// depends on kns_pkg (kns_tap_t, widths)
module kns_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ins,
  input  logic [kns_pkg::DIST_BITS-1:0] cand_dist,
  input  logic [kns_pkg::ITEM_BITS-1:0] cand_item,
  input  kns_pkg::kns_tap_t             prev,
  output kns_pkg::kns_tap_t             tap
);

  logic                          valid_r, valid_nxt;
  logic [kns_pkg::DIST_BITS-1:0] dist_r, dist_nxt;
  logic [kns_pkg::ITEM_BITS-1:0] item_r, item_nxt;
  logic                          gt;

  // compare own entry against the candidate
  assign gt = valid_r && (dist_r > cand_dist);

  always_comb begin
    tap.valid    = valid_r;
    tap.gt       = gt;
    tap.le       = valid_r && !gt;
    tap.dist_val = dist_r;
    tap.item     = item_r;
  end

  // shift from left neighbor, take candidate, or hold
  always_comb begin
    valid_nxt = valid_r;
    dist_nxt  = dist_r;
    item_nxt  = item_r;
    priority if (ins && prev.gt) begin
      valid_nxt = 1'b1;
      dist_nxt  = prev.dist_val;
      item_nxt  = prev.item;
    end else if (ins && prev.le && !tap.le) begin
      valid_nxt = 1'b1;
      dist_nxt  = cand_dist;
      item_nxt  = cand_item;
    end
  end

  // valid flag is control, entry payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    item_r <= item_nxt;
  end

endmodule

### tb/tb.sv
// testbench for k_nearest_sorted_insert_unit: checks the sorted top-k list against a
// behavioral copy of the list held here, with random request and result stalls
// depends on kns_pkg and k_nearest_sorted_insert_unit
`timescale 1ns / 1ps

module tb;

  // register index that the block does not implement
  localparam int UNUSED_REG_IDX = 1;
  localparam int PHASES         = 4;
  localparam int PHASE_ITEMS    = 332;

  typedef struct {
    bit                                is_cfg;
    int                                reg_idx;
    logic [kns_pkg::CFG_DATA_BITS-1:0] reg_val;
    kns_pkg::kns_in_t                  req;
    bit                                typed;
    kns_pkg::kns_out_t                 want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  kns_pkg::kns_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  kns_pkg::kns_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [kns_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
  logic [kns_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
  logic [kns_pkg::CFG_DATA_BITS-1:0] prdata;
  logic pready;

  // shadow of the kept list and the empty-list sentinel
  logic [kns_pkg::DIST_BITS-1:0] kept_dist [kns_pkg::CAPACITY];
  logic [kns_pkg::ITEM_BITS-1:0] kept_item [kns_pkg::CAPACITY];
  int                            kept_n;
  logic [kns_pkg::DIST_BITS-1:0] empty_sentinel;

  kns_pkg::kns_out_t due_results [$];
  kns_pkg::kns_out_t oldest_due;
  bit       stall_en = 1'b1;
  int       n_fail = 0;
  int       n_results = 0;
  int       n_kept = 0;
  int       n_dropped = 0;
  int       n_reads = 0;
  int       n_read_oor = 0;
  int       n_reg_writes = 0;

  k_nearest_sorted_insert_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // one request through the shadow list: insert or read, then the status fields
  function automatic kns_pkg::kns_out_t list_step(kns_pkg::kns_in_t r);
    kns_pkg::kns_out_t o;
    int pos;
    int i;
    o = '0;
    if (r.command == kns_pkg::CMD_INSERT) begin
      if (kept_n == kns_pkg::CAPACITY && r.distance >= kept_dist[kns_pkg::CAPACITY-1]) begin
        n_dropped++;
      end else begin
        // ties stay in arrival order: go after every entry not greater
        pos = 0;
        while (pos < kept_n && kept_dist[pos] <= r.distance) pos++;
        if (kept_n < kns_pkg::CAPACITY) kept_n++;
        for (i = kept_n - 1; i > pos; i--) begin
          kept_dist[i] = kept_dist[i-1];
          kept_item[i] = kept_item[i-1];
        end
        kept_dist[pos] = r.distance;
        kept_item[pos] = r.item_id;
        o.inserted = 1'b1;
        n_kept++;
      end
    end else begin
      n_reads++;
      if (int'(r.entry_index) < kept_n) begin
        o.read_item     = kept_item[r.entry_index];
        o.read_distance = kept_dist[r.entry_index];
      end else begin
        o.read_error = 1'b1;
        n_read_oor++;
      end
    end
    o.entry_count = kns_pkg::CNT_BITS'(kept_n);
    if (kept_n > 0) begin
      o.worst_distance = kept_dist[kept_n-1];
      o.nearest_valid  = 1'b1;
      o.nearest_item   = kept_item[0];
    end else begin
      o.worst_distance = empty_sentinel;
    end
    return o;
  endfunction

  function automatic kns_pkg::kns_in_t mk_req(kns_pkg::kns_cmd_t c,
                                              logic [kns_pkg::ITEM_BITS-1:0] item,
                                              logic [kns_pkg::DIST_BITS-1:0] dval,
                                              logic [kns_pkg::IDX_BITS-1:0] idx);
    kns_pkg::kns_in_t r;
    r.command     = c;
    r.item_id     = item;
    r.distance    = dval;
    r.entry_index = idx;
    return r;
  endfunction

  function automatic kns_pkg::kns_out_t mk_out(logic ins, logic [kns_pkg::CNT_BITS-1:0] cnt,
                                               logic [kns_pkg::DIST_BITS-1:0] worst,
                                               logic nv,
                                               logic [kns_pkg::ITEM_BITS-1:0] near,
                                               logic [kns_pkg::ITEM_BITS-1:0] ritem,
                                               logic [kns_pkg::DIST_BITS-1:0] rdist,
                                               logic rerr);
    kns_pkg::kns_out_t o;
    o.inserted       = ins;
    o.entry_count    = cnt;
    o.worst_distance = worst;
    o.nearest_valid  = nv;
    o.nearest_item   = near;
    o.read_item      = ritem;
    o.read_distance  = rdist;
    o.read_error     = rerr;
    return o;
  endfunction

  function automatic dir_row_t req_row(kns_pkg::kns_in_t r);
    dir_row_t d;
    d = '{default: '0};
    d.req = r;
    return d;
  endfunction

  function automatic dir_row_t typed_row(kns_pkg::kns_in_t r, kns_pkg::kns_out_t w);
    dir_row_t d;
    d = '{default: '0};
    d.req   = r;
    d.typed = 1'b1;
    d.want  = w;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(int idx, logic [kns_pkg::CFG_DATA_BITS-1:0] v);
    dir_row_t d;
    d = '{default: '0};
    d.is_cfg  = 1'b1;
    d.reg_idx = idx;
    d.reg_val = v;
    return d;
  endfunction

  // random request, biased to land near the current worst distance so the list keeps moving
  function automatic kns_pkg::kns_in_t random_req();
    kns_pkg::kns_in_t r;
    int unsigned sel;
    logic [kns_pkg::DIST_BITS-1:0] w;
    r.item_id     = kns_pkg::ITEM_BITS'($urandom);
    r.distance    = $urandom;
    r.entry_index = kns_pkg::IDX_BITS'($urandom);
    r.command     = kns_pkg::CMD_INSERT;
    w = (kept_n > 0) ? kept_dist[kept_n-1] : '1;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      r.command = kns_pkg::CMD_READ;
    end else if (sel < 60) begin
      r.distance = w - kns_pkg::DIST_BITS'($urandom_range(0, w >> 6));
    end else if (sel < 72 && kept_n > 0) begin
      r.distance = kept_dist[$urandom_range(0, kept_n - 1)];
    end else if (sel < 80) begin
      r.distance = w;
    end else if (sel < 88) begin
      r.distance = w + kns_pkg::DIST_BITS'($urandom_range(1, 1000));
    end else if (sel < 96 && sel >= 93) begin
      r.distance = kns_pkg::DIST_BITS'($urandom_range(0, 255));
    end else if (sel >= 96) begin
      r.distance = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end
    return r;
  endfunction

  task automatic check_result(kns_pkg::kns_out_t got, kns_pkg::kns_out_t want);
    if (got.inserted !== want.inserted) begin
      $error("inserted: expected %0d, got %0d", want.inserted, got.inserted);
      n_fail++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      n_fail++;
    end
    if (got.worst_distance !== want.worst_distance) begin
      $error("worst_distance: expected %0h, got %0h", want.worst_distance, got.worst_distance);
      n_fail++;
    end
    if (got.nearest_valid !== want.nearest_valid) begin
      $error("nearest_valid: expected %0d, got %0d", want.nearest_valid, got.nearest_valid);
      n_fail++;
    end
    if (got.nearest_item !== want.nearest_item) begin
      $error("nearest_item: expected %0h, got %0h", want.nearest_item, got.nearest_item);
      n_fail++;
    end
    if (got.read_item !== want.read_item) begin
      $error("read_item: expected %0h, got %0h", want.read_item, got.read_item);
      n_fail++;
    end
    if (got.read_distance !== want.read_distance) begin
      $error("read_distance: expected %0h, got %0h", want.read_distance, got.read_distance);
      n_fail++;
    end
    if (got.read_error !== want.read_error) begin
      $error("read_error: expected %0d, got %0d", want.read_error, got.read_error);
      n_fail++;
    end
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    out_ready <= (stall_en && $urandom_range(0, 99) < 25) ? 1'b0 : 1'b1;
  end

  // result side: compare each accepted result with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        oldest_due = due_results.pop_front();
        check_result(out_data, oldest_due);
      end
    end
  end

  // hold one request until accepted, then record what it should produce
  task automatic send_req(kns_pkg::kns_in_t r, bit typed, kns_pkg::kns_out_t want);
    kns_pkg::kns_out_t pred;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    pred = list_step(r);
    due_results.push_back(typed ? want : pred);
  endtask

  // random gap after a request
  task automatic maybe_idle();
    if (stall_en && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // apb write, then read back when the register exists
  task automatic write_reg(int idx, logic [kns_pkg::CFG_DATA_BITS-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= kns_pkg::CFG_ADDR_BITS'(idx * 4);
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    n_reg_writes++;
    if (idx == int'(kns_pkg::REG_EMPTY_MAX)) begin
      empty_sentinel = v;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== v) begin
        $error("empty_max_distance readback: expected %0h, got %0h", v, prdata);
        n_fail++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    dir_row_t tab [$];
    dir_row_t row;
    int k;
    int ph;
    int guard;

    kept_n = 0;
    empty_sentinel = kns_pkg::EMPTY_MAX_RESET;
    for (k = 0; k < kns_pkg::CAPACITY; k++) begin
      kept_dist[k] = '0;
      kept_item[k] = '0;
    end

    // empty list under several sentinels, including an unimplemented register
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_READ, 16'h0, 32'h0, 4'd0),
                            mk_out(1'b0, 5'd0, kns_pkg::EMPTY_MAX_RESET, 1'b0, 16'h0,
                                   16'h0, 32'h0, 1'b1)));
    tab.push_back(cfg_row(kns_pkg::REG_EMPTY_MAX, 32'h0));
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_READ, 16'hFFFF, '1, 4'd15),
                            mk_out(1'b0, 5'd0, 32'h0, 1'b0, 16'h0, 16'h0, 32'h0, 1'b1)));
    tab.push_back(cfg_row(kns_pkg::REG_EMPTY_MAX, '1));
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_READ, 16'h1234, 32'h55, 4'd0),
                            mk_out(1'b0, 5'd0, '1, 1'b0, 16'h0, 16'h0, 32'h0, 1'b1)));
    tab.push_back(cfg_row(UNUSED_REG_IDX, 32'h1234_5678));
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_READ, 16'h0, 32'h0, 4'd7),
                            mk_out(1'b0, 5'd0, '1, 1'b0, 16'h0, 16'h0, 32'h0, 1'b1)));
    // extremes and a tie at distance zero
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_INSERT, 16'hFFFF, '1, 4'd0),
                            mk_out(1'b1, 5'd1, '1, 1'b1, 16'hFFFF, 16'h0, 32'h0, 1'b0)));
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_INSERT, 16'h0, 32'h0, 4'd15),
                            mk_out(1'b1, 5'd2, '1, 1'b1, 16'h0, 16'h0, 32'h0, 1'b0)));
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_INSERT, 16'h1, 32'h0, 4'd0),
                            mk_out(1'b1, 5'd3, '1, 1'b1, 16'h0, 16'h0, 32'h0, 1'b0)));
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_READ, 16'h0, 32'h0, 4'd1),
                            mk_out(1'b0, 5'd3, '1, 1'b1, 16'h0, 16'h1, 32'h0, 1'b0)));
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_READ, 16'h0, 32'h0, 4'd2),
                            mk_out(1'b0, 5'd3, '1, 1'b1, 16'h0, 16'hFFFF, '1, 1'b0)));
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_READ, 16'h0, 32'h0, 4'd3),
                            mk_out(1'b0, 5'd3, '1, 1'b1, 16'h0, 16'h0, 32'h0, 1'b1)));
    // fill the list out of order
    for (k = 0; k < 13; k++) begin
      tab.push_back(req_row(mk_req(kns_pkg::CMD_INSERT, 16'h0100 + 16'(k),
                                   32'hF000_0000 + 32'((k * 7) % 13) * 32'h0010_0000,
                                   4'(k))));
    end
    // full list: equal to worst is dropped, a small one pushes the worst off
    tab.push_back(typed_row(mk_req(kns_pkg::CMD_INSERT, 16'h7777, '1, 4'd0),
                            mk_out(1'b0, 5'd16, '1, 1'b1, 16'h0, 16'h0, 32'h0, 1'b0)));
    tab.push_back(req_row(mk_req(kns_pkg::CMD_INSERT, 16'hA5A5, 32'd5, 4'd0)));
    tab.push_back(req_row(mk_req(kns_pkg::CMD_READ, 16'hFFFF, '1, 4'd15)));
    tab.push_back(req_row(mk_req(kns_pkg::CMD_INSERT, 16'h5A5A, 32'hF0C0_0000, 4'd9)));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (tab[k]) begin
      row = tab[k];
      if (row.is_cfg) begin
        drain();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_req(row.req, row.typed, row.want);
        maybe_idle();
      end
    end

    // random phases; the second runs with no gaps on either side
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: write_reg(kns_pkg::REG_EMPTY_MAX, $urandom);
        1: write_reg(kns_pkg::REG_EMPTY_MAX, '0);
        2: write_reg(kns_pkg::REG_EMPTY_MAX, '1);
        default: write_reg(kns_pkg::REG_EMPTY_MAX, $urandom);
      endcase
      stall_en = (ph != 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain();
        send_req(random_req(), 1'b0, '0);
        maybe_idle();
      end
    end
    in_valid <= 1'b0;

    // wait out the remaining results
    guard = 0;
    while (due_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      n_fail++;
    end

    $display("run: %0d results checked, %0d inserts kept, %0d dropped",
             n_results, n_kept, n_dropped);
    $display("run: %0d reads (%0d out of range), %0d register writes, sentinel at zero,",
             n_reads, n_read_oor, n_reg_writes);
    $display("run: all ones and random values");
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/kns_pkg.sv
sv/kns_cell.sv
sv/k_nearest_sorted_insert_unit.sv
tb/tb.sv
